### src/hue_band_qualifier_macros.svh
// ----------------------------------------------------------------------------
// hue band qualifier assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HUE_BAND_QUALIFIER_MACROS_SVH
`define HUE_BAND_QUALIFIER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define HBQ_ASSERT(label, clock, rst_n_sig, prop) \
    label: assert property (@(posedge clock) disable iff (!(rst_n_sig)) (prop)) \
        else $error("hbq assertion failed");

// implication form
`define HBQ_ASSERT_IMPL(label, clock, rst_n_sig, ante, cons) \
    `HBQ_ASSERT(label, clock, rst_n_sig, (ante) |-> (cons))

`endif

### src/hbq_pkg.sv
// ----------------------------------------------------------------------------
// hbq_pkg
// shared constants and types of the hue band qualifier
// ----------------------------------------------------------------------------
package hbq_pkg;

    localparam int BANDS_DEFAULT = 4;
    localparam int BAND_REGS     = 4;
    localparam int BAND_W        = 39;
    localparam int HUE_W         = 8;
    localparam int LEVEL_W       = 8;
    localparam int MEMB_W        = 17;
    localparam int CFG_IDX_W     = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_0        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_1        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_2        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_3        = 3'd5;

    // angle constants in 1/16 and 1/32 degree
    localparam logic [12:0] TURN16      = 13'd5760;
    localparam logic [12:0] NEAR_TURN16 = 13'd5752;
    localparam logic [11:0] HALF_TURN16 = 12'd2880;
    localparam logic [13:0] TURN32      = 14'd11520;
    localparam logic [HUE_W-1:0] HUE_BINS = 8'd180;

    localparam logic [MEMB_W-1:0] MEMB_ONE = 17'd65536;

    // division steps, one per stage
    localparam int DIV_STEPS = MEMB_W;
    // stages ahead of the divider: distance, squares, cubes, dividend
    localparam int BAND_LAT  = 4 + DIV_STEPS;
    // start to done: input, band, max, level stages
    localparam int PIPE_LAT  = BAND_LAT + 3;

    typedef struct packed {
        logic full;
        logic zero;
    } memb_flags_t;

endpackage

### src/hue_band_qualifier.sv
// ----------------------------------------------------------------------------
// hue_band_qualifier
// soft-keyed hue range qualifier for hsv hue bins, one pixel per clock
// ----------------------------------------------------------------------------
// One hue bin is taken at every clock edge where start is high (busy is
// always low), and its two levels appear on selection_level and
// applied_level with done high for one cycle, after an input stage, the
// band pipelines, a max stage and a level stage. Each band pipeline ends
// in a restoring divider, which produces one of the 17 membership bits
// per stage, with four stages ahead of it for the distance, the squares,
// the cubes and the rounded dividend. Results leave in start order and
// there is no way to hold them off, so the consumer must take done every
// cycle it comes. Configuration is written through cfg_we, cfg_index and
// cfg_data and must not change while pixels are in flight.
// ----------------------------------------------------------------------------
module hue_band_qualifier #(
    parameter int BANDS = hbq_pkg::BANDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel transfer
    input  logic                           start,
    output logic                           busy,
    input  logic [hbq_pkg::HUE_W-1:0]      hue_bin,
    // result transfer
    output logic                           done,
    output logic [hbq_pkg::LEVEL_W-1:0]    selection_level,
    output logic [hbq_pkg::LEVEL_W-1:0]    applied_level,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [hbq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbq_pkg::BAND_W-1:0]     cfg_data
);
    import hbq_pkg::*;

    // never stalls
    assign busy = 1'b0;

    // configuration registers; all four band words are stored
    logic                master_en_reg;
    logic                exclude_reg;
    logic [BAND_W-1:0]   band_word_reg [0:BAND_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_en_reg <= 1'b0;
            exclude_reg   <= 1'b0;
            for (int i = 0; i < BAND_REGS; i++)
            begin
                band_word_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASTER_ENABLE: master_en_reg    <= cfg_data[0];
                REG_EXCLUDE_MODE:  exclude_reg      <= cfg_data[0];
                REG_BAND_0:        band_word_reg[0] <= cfg_data;
                REG_BAND_1:        band_word_reg[1] <= cfg_data;
                REG_BAND_2:        band_word_reg[2] <= cfg_data;
                REG_BAND_3:        band_word_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // qualifier is live only with master enable and an enabled band of nonzero width
    logic active;

    always_comb
    begin
        active = 1'b0;
        for (int i = 0; i < BANDS; i++)
        begin
            if (band_word_reg[i][0] && (band_word_reg[i][26:14] != 13'd0))
            begin
                active = 1'b1;
            end
        end
        active = active && master_en_reg;
    end

    // input stage
    logic              vld0_reg;
    logic              ok0_reg;
    logic [HUE_W-1:0]  bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ok0_reg <= active && (hue_bin < HUE_BINS);
        bin_reg <= hue_bin;
    end

    // per-band membership pipelines
    logic [MEMB_W-1:0] memb [0:BANDS-1];

    for (genvar b = 0; b < BANDS; b++)
    begin : g_band
        hbq_band u_band (
            .clk        (clk),
            .band_word  (band_word_reg[b]),
            .hue_bin    (bin_reg),
            .membership (memb[b])
        );
    end

    // valid and in-range flag travel alongside the band pipelines
    logic vld_pipe_reg [0:BAND_LAT-1];
    logic ok_pipe_reg  [0:BAND_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BAND_LAT; i++)
            begin
                vld_pipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_pipe_reg[0] <= vld0_reg;
            for (int i = 1; i < BAND_LAT; i++)
            begin
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_pipe_reg[0] <= ok0_reg;
        for (int i = 1; i < BAND_LAT; i++)
        begin
            ok_pipe_reg[i] <= ok_pipe_reg[i-1];
        end
    end

    // max over bands
    logic [MEMB_W-1:0] m_next;
    logic [MEMB_W-1:0] m_reg;
    logic              vldm_reg;
    logic              okm_reg;

    always_comb
    begin
        m_next = '0;
        for (int i = 0; i < BANDS; i++)
        begin
            if (memb[i] > m_next)
            begin
                m_next = memb[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldm_reg <= 1'b0;
        end
        else
        begin
            vldm_reg <= vld_pipe_reg[BAND_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        okm_reg <= ok_pipe_reg[BAND_LAT-1];
    end

    // levels: round half up of m * 255 / 65536
    logic [MEMB_W-1:0]   inv_m;
    logic [25:0]         sel_sum;
    logic [25:0]         inv_sum;
    logic [LEVEL_W-1:0]  sel_next;
    logic [LEVEL_W-1:0]  app_next;

    always_comb
    begin
        inv_m   = MEMB_ONE - m_reg;
        sel_sum = {1'b0, m_reg, 8'b0} - {9'b0, m_reg} + 26'd32768;
        inv_sum = {1'b0, inv_m, 8'b0} - {9'b0, inv_m} + 26'd32768;
        if (!okm_reg)
        begin
            sel_next = '0;
            app_next = exclude_reg ? {LEVEL_W{1'b1}} : '0;
        end
        else
        begin
            sel_next = sel_sum[23:16];
            app_next = exclude_reg ? inv_sum[23:16] : sel_sum[23:16];
        end
    end

    logic               done_reg;
    logic [LEVEL_W-1:0] sel_reg;
    logic [LEVEL_W-1:0] app_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vldm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        app_reg <= app_next;
    end

    assign done            = done_reg;
    assign selection_level = sel_reg;
    assign applied_level   = app_reg;

endmodule

### src/hbq_band.sv
// ----------------------------------------------------------------------------
// hbq_band
// membership of one hue in one band, pipelined through stages a to d and the divider
// ----------------------------------------------------------------------------
module hbq_band (
    input  logic                        clk,
    input  logic [hbq_pkg::BAND_W-1:0]  band_word,
    input  logic [hbq_pkg::HUE_W-1:0]   hue_bin,
    output logic [hbq_pkg::MEMB_W-1:0]  membership
);
    import hbq_pkg::*;

    // stage a: circular distance and band edges
    logic [12:0] centre16;
    logic [12:0] width16;
    logic [11:0] soft16;
    logic [12:0] feather;
    logic [13:0] hue32;
    logic [13:0] centre32;
    logic [13:0] diff;
    logic [13:0] wrap_diff;
    logic [13:0] arc_dist;
    logic [13:0] outer;
    logic        is_full;
    memb_flags_t flg_a_next;
    logic [12:0] a_next;

    memb_flags_t flg_a_reg;
    logic [12:0] a_reg;
    logic [12:0] f_a_reg;

    always_comb
    begin
        centre16 = band_word[13:1];
        if (centre16 >= TURN16)
        begin
            centre16 = centre16 - TURN16;
        end
        width16 = band_word[26:14];
        if (width16 > TURN16)
        begin
            width16 = TURN16;
        end
        soft16 = band_word[38:27];
        if (soft16 > HALF_TURN16)
        begin
            soft16 = HALF_TURN16;
        end
        feather   = {soft16, 1'b0};
        hue32     = {hue_bin, 6'b0};
        centre32  = {centre16, 1'b0};
        diff      = (hue32 > centre32) ? (hue32 - centre32) : (centre32 - hue32);
        wrap_diff = TURN32 - diff;
        arc_dist  = (wrap_diff < diff) ? wrap_diff : diff;
        outer     = {1'b0, width16} + {1'b0, feather};
        is_full   = (width16 >= NEAR_TURN16) || (arc_dist <= {1'b0, width16});
        flg_a_next.full = band_word[0] && is_full;
        flg_a_next.zero = !band_word[0]
                          || (!is_full && ((feather == 13'd0) || (arc_dist >= outer)));
        a_next = arc_dist[12:0] - width16;
    end

    always_ff @(posedge clk)
    begin
        flg_a_reg <= flg_a_next;
        a_reg     <= a_next;
        f_a_reg   <= feather;
    end

    // stage b: squares and linear term
    logic [12:0] fa;
    memb_flags_t flg_b_reg;
    logic [25:0] fa2_reg;
    logic [25:0] ff_reg;
    logic [14:0] t_reg;
    logic [12:0] f_b_reg;

    assign fa = f_a_reg - a_reg;

    always_ff @(posedge clk)
    begin
        flg_b_reg <= flg_a_reg;
        fa2_reg   <= fa * fa;
        ff_reg    <= f_a_reg * f_a_reg;
        t_reg     <= {2'b0, f_a_reg} + {1'b0, a_reg, 1'b0};
        f_b_reg   <= f_a_reg;
    end

    // stage c: numerator and denominator cubes (both stay below 2^38)
    logic [40:0] num_full;
    logic [38:0] den_full;
    memb_flags_t flg_c_reg;
    logic [37:0] num_reg;
    logic [37:0] den_c_reg;

    assign num_full = fa2_reg * t_reg;
    assign den_full = ff_reg * f_b_reg;

    always_ff @(posedge clk)
    begin
        flg_c_reg <= flg_b_reg;
        num_reg   <= num_full[37:0];
        den_c_reg <= den_full[37:0];
    end

    // stage d: rounded dividend num * 2^16 + den / 2
    logic [54:0] dividend;

    assign dividend = {1'b0, num_reg, 16'b0} + {18'b0, den_c_reg[37:1]};

    memb_flags_t             flg_reg [0:DIV_STEPS];
    logic [37:0]             rem_reg [0:DIV_STEPS-1];
    logic [37:0]             den_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0]    nlo_reg [0:DIV_STEPS-1];
    logic [MEMB_W-1:0]       q_reg   [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        flg_reg[0] <= flg_c_reg;
        rem_reg[0] <= dividend[54:17];
        nlo_reg[0] <= dividend[16:0];
        den_reg[0] <= den_c_reg;
        q_reg[0]   <= '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [38:0] trial;
        logic [38:0] diff_t;
        logic        take;

        assign trial  = {rem_reg[k], nlo_reg[k][BIT]};
        assign diff_t = trial - {1'b0, den_reg[k]};
        assign take   = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            flg_reg[k+1] <= flg_reg[k];
            q_reg[k+1]   <= {q_reg[k][MEMB_W-2:0], take};
        end

        if (k < DIV_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= take ? diff_t[37:0] : trial[37:0];
                nlo_reg[k+1] <= nlo_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    always_comb
    begin
        if (flg_reg[DIV_STEPS].full)
        begin
            membership = MEMB_ONE;
        end
        else if (flg_reg[DIV_STEPS].zero)
        begin
            membership = '0;
        end
        else
        begin
            membership = q_reg[DIV_STEPS];
        end
    end

endmodule

### src/hbq_checker.sv
// ----------------------------------------------------------------------------
// hbq_checker
// port-level checks of the hue band qualifier, bound to the top level
// ----------------------------------------------------------------------------
`include "hue_band_qualifier_macros.svh"

module hbq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [hbq_pkg::LEVEL_W-1:0]   selection_level,
    input logic [hbq_pkg::LEVEL_W-1:0]   applied_level
);
    import hbq_pkg::*;

    // every transfer in comes out as one done, in order, and no done comes without one
    `HBQ_ASSERT_IMPL(a_latency, clk, rst_n, $past(rst_n, PIPE_LAT), done == $past(start && !busy, PIPE_LAT))
    // the block never holds off a pixel
    `HBQ_ASSERT(a_no_busy, clk, rst_n, !busy)
    // no selection leaves applied at one of the two extremes
    `HBQ_ASSERT_IMPL(a_zero_sel, clk, rst_n, done && (selection_level == 8'd0), (applied_level == 8'd0) || (applied_level == 8'd255))
    // full selection leaves applied at one of the two extremes
    `HBQ_ASSERT_IMPL(a_full_sel, clk, rst_n, done && (selection_level == 8'd255), (applied_level == 8'd0) || (applied_level == 8'd255))

endmodule

bind hue_band_qualifier hbq_checker u_hbq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .selection_level (selection_level),
    .applied_level   (applied_level)
);

### bench/tb_hue_band_qualifier.sv
// ----------------------------------------------------------------------------
// tb_hue_band_qualifier
// self-checking bench: drives hue bins and band settings through the ports,
// predicts both levels per pixel and compares every result in order
// ----------------------------------------------------------------------------
module tb_hue_band_qualifier;

    import hbq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = PIPE_LAT + 8;

    typedef struct packed {
        logic [LEVEL_W-1:0] sel;
        logic [LEVEL_W-1:0] app;
    } levels_t;

    // expected levels per pixel, computed from a private copy of the registers
    class level_scoreboard;
        bit                master;
        bit                excl;
        logic [BAND_W-1:0] band_words [BAND_REGS];
        levels_t           pending [$];
        int                mismatches;

        function new();
            master     = 1'b0;
            excl       = 1'b0;
            mismatches = 0;
            foreach (band_words[i]) band_words[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BAND_W-1:0] data);
            case (idx)
                REG_MASTER_ENABLE: master = data[0];
                REG_EXCLUDE_MODE:  excl = data[0];
                REG_BAND_0:        band_words[0] = data;
                REG_BAND_1:        band_words[1] = data;
                REG_BAND_2:        band_words[2] = data;
                REG_BAND_3:        band_words[3] = data;
                default:           ;
            endcase
        endfunction

        // one band's membership, 1.0 = 65536
        function longint unsigned band_membership(logic [BAND_W-1:0] w,
                                                  longint unsigned hue32);
            longint unsigned centre, width, softness, core, feather, arc, a, fa, num, den;
            if (!w[0]) return 0;
            centre   = w[13:1];
            width    = w[26:14];
            softness = w[38:27];
            if (centre >= 5760) centre = centre - 5760;
            if (width > 5760) width = 5760;
            if (softness > 2880) softness = 2880;
            if (width >= 5752) return 65536;
            centre  = centre * 2;
            core    = width;
            feather = softness * 2;
            arc = hue32 > centre ? hue32 - centre : centre - hue32;
            if (11520 - arc < arc) arc = 11520 - arc;
            if (arc <= core) return 65536;
            if (feather == 0) return 0;
            if (arc >= core + feather) return 0;
            a   = arc - core;
            fa  = feather - a;
            num = fa * fa * (feather + 2 * a);
            den = feather * feather * feather;
            return (num * 65536 + den / 2) / den;
        endfunction

        function levels_t predict_levels(logic [HUE_W-1:0] bin);
            levels_t         r;
            bit              active;
            longint unsigned m, b;
            active = 1'b0;
            m = 0;
            if (master)
                foreach (band_words[i])
                    if (band_words[i][0] && band_words[i][26:14] != 0) active = 1'b1;
            if (!active || bin >= 180) begin
                r.sel = '0;
                r.app = excl ? 8'd255 : 8'd0;
                return r;
            end
            foreach (band_words[i]) begin
                b = band_membership(band_words[i], longint'(bin) * 64);
                if (b > m) m = b;
            end
            r.sel = LEVEL_W'((m * 255 + 32768) >> 16);
            r.app = excl ? LEVEL_W'(((65536 - m) * 255 + 32768) >> 16) : r.sel;
            return r;
        endfunction

        function void note_pixel(logic [HUE_W-1:0] bin);
            pending.push_back(predict_levels(bin));
        endfunction

        function void check_result(logic [LEVEL_W-1:0] sel, logic [LEVEL_W-1:0] app);
            levels_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sel=%0d app=%0d", sel, app);
                return;
            end
            want = pending.pop_front();
            if (want.sel !== sel || want.app !== app) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("level mismatch: expected sel=%0d app=%0d, got sel=%0d app=%0d",
                             want.sel, want.app, sel, app);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [HUE_W-1:0]     hue_bin;
    logic                 done;
    logic [LEVEL_W-1:0]   selection_level;
    logic [LEVEL_W-1:0]   applied_level;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BAND_W-1:0]    cfg_data;

    level_scoreboard sb;
    int              idle_pct;
    int              quiet_cycles;

    hue_band_qualifier u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .hue_bin         (hue_bin),
        .done            (done),
        .selection_level (selection_level),
        .applied_level   (applied_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // monitor: a pixel transfer is start && !busy at the edge, a result
    // transfer is done; both see pre-edge values since drives are nonblocking
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_pixel(hue_bin);
            if (done)
                sb.check_result(selection_level, applied_level);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            // watchdog on a stuck handshake or missing results
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // one pixel, with a random idle gap ahead of it; start stays high
    // across back-to-back pixels so it is never lowered and raised in a step
    task automatic send_pixel(logic [HUE_W-1:0] bin);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        hue_bin <= bin;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BAND_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic logic [BAND_W-1:0] pack_band(bit en, int centre, int width,
                                                    int softness);
        return {softness[11:0], width[12:0], centre[12:0], en};
    endfunction

    function automatic logic [BAND_W-1:0] rand_word();
        return BAND_W'({$urandom, $urandom});
    endfunction

    // random band: mostly sensible arcs, sometimes raw bits for the wrap
    // and saturation cases
    function automatic logic [BAND_W-1:0] rand_band();
        case ($urandom_range(9))
            0:       return rand_word();
            1:       return pack_band(1, $urandom_range(8191), $urandom_range(5740, 8191),
                                      $urandom_range(4095));
            2:       return pack_band($urandom_range(1), $urandom_range(5759), 0,
                                      $urandom_range(400));
            default: return pack_band($urandom_range(3) != 0, $urandom_range(5759),
                                      $urandom_range(1600), $urandom_range(1600));
        endcase
    endfunction

    // registers: master and exclude carry random upper bits, which must be ignored
    task automatic set_config(bit master, bit excl, logic [BAND_W-1:0] b0,
                              logic [BAND_W-1:0] b1, logic [BAND_W-1:0] b2,
                              logic [BAND_W-1:0] b3);
        logic [BAND_W-1:0] junk;
        junk = rand_word();
        write_reg(REG_MASTER_ENABLE, {junk[BAND_W-1:1], master});
        junk = rand_word();
        write_reg(REG_EXCLUDE_MODE, {junk[BAND_W-1:1], excl});
        write_reg(REG_BAND_0, b0);
        write_reg(REG_BAND_1, b1);
        write_reg(REG_BAND_2, b2);
        write_reg(REG_BAND_3, b3);
    endtask

    function automatic logic [HUE_W-1:0] rand_bin();
        return $urandom_range(9) == 0 ? HUE_W'($urandom_range(180, 255))
                                      : HUE_W'($urandom_range(179));
    endfunction

    initial
    begin
        int n;
        logic [HUE_W-1:0] dir_bins [14];
        sb           = new();
        quiet_cycles = 0;
        idle_pct     = 23;
        rst_n        = 1'b0;
        start        = 1'b0;
        hue_bin      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: inactive, levels zero
        send_pixel(8'd0);
        send_pixel(8'd90);
        drain_pipe();

        // directed: narrow soft band at zero (wraps across 358 deg), a centre
        // beyond a turn, a zero-width band, include mode
        set_config(1, 0, pack_band(1, 0, 320, 160), pack_band(1, 5760 + 1440, 64, 0),
                   pack_band(1, 2880, 0, 200), pack_band(0, 0, 8191, 4095));
        dir_bins = '{8'd0, 8'd1, 8'd5, 8'd10, 8'd15, 8'd175, 8'd179, 8'd45, 8'd46,
                     8'd90, 8'd91, 8'd92, 8'd180, 8'd255};
        foreach (dir_bins[i])
            send_pixel(dir_bins[i]);
        drain_pipe();

        // directed: saturated width and softness, exclude mode
        set_config(1, 1, '1, pack_band(1, 100, 0, 0), '0, '0);
        send_pixel(8'd0);
        send_pixel(8'd179);
        send_pixel(8'd200);
        drain_pipe();
        // only zero-width bands: inactive despite the exact hit
        set_config(1, 1, pack_band(1, 0, 0, 4095), pack_band(1, 5760, 0, 0), '0, '0);
        send_pixel(8'd0);
        send_pixel(8'd3);
        drain_pipe();
        // master off with a full band
        set_config(0, 1, '1, '1, '1, '1);
        send_pixel(8'd10);
        send_pixel(8'd255);
        drain_pipe();

        // random phases with the idle mix changing by thirds
        n = 0;
        while (n < 1450) begin
            idle_pct = n < 480 ? 23 : (n < 960 ? 60 : 0);
            if ($urandom_range(11) == 0)
                set_config($urandom_range(1), $urandom_range(1), rand_word(), rand_word(),
                           rand_word(), rand_word());
            else
                set_config($urandom_range(7) != 0, $urandom_range(1), rand_band(),
                           rand_band(), rand_band(), rand_band());
            repeat ($urandom_range(60, 130)) begin
                send_pixel(rand_bin());
                n++;
            end
            // full hold-off until everything is back before reconfiguring
            drain_pipe();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
